FILE: sv/lsd_radix_sort_bytes_top_macros.svh
// Assertion shorthands used by the sorter top level
`ifndef LSD_RADIX_SORT_BYTES_TOP_MACROS_SVH
`define LSD_RADIX_SORT_BYTES_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define LSDR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define LSDR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/lsdr_pkg.sv
package lsdr_pkg;

	// Fixed field widths of the item and result ports
	localparam int KEY_PORT_BITS     = 64;
	localparam int PAYLOAD_PORT_BITS = 32;

	// Digit geometry
	localparam int DIGIT_BITS = 8;
	localparam int RADIX_BINS = 256;
	localparam logic [DIGIT_BITS-1:0] DIGIT_MASK = 8'hFF;

	// Results released per accepted item while a sorted set drains
	localparam int OUT_CHUNK = 64;

	// Parameter defaults
	localparam int MAX_ITEMS_DEF    = 1024;
	localparam int KEY_BYTES_DEF    = 8;
	localparam int PAYLOAD_BITS_DEF = 32;

	// Sequencer states
	typedef enum logic [12:0] {
		ST_IDLE   = 13'b0000000000001,
		ST_CLR    = 13'b0000000000010,
		ST_CNT_RD = 13'b0000000000100,
		ST_CNT_H  = 13'b0000000001000,
		ST_CNT_W  = 13'b0000000010000,
		ST_PFX_RD = 13'b0000000100000,
		ST_PFX_W  = 13'b0000001000000,
		ST_SC_RD  = 13'b0000010000000,
		ST_SC_H   = 13'b0000100000000,
		ST_SC_W   = 13'b0001000000000,
		ST_OUT_RD = 13'b0010000000000,
		ST_OUT_WT = 13'b0100000000000,
		ST_DRAIN  = 13'b1000000000000
	} lsdr_state_t;

endpackage

FILE: sv/lsdr_item_ram.sv
module lsdr_item_ram import lsdr_pkg::*; #(
	parameter int AW = 11,
	parameter int DW = KEY_PORT_BITS + PAYLOAD_PORT_BITS
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [2**AW];
	logic [DW-1:0] rd_data_q;

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

FILE: sv/lsd_radix_sort_bytes_top.sv
// Stable LSD radix sorter, 8-bit digits. Items enter one per cycle while the
// block collects; final_item closes the set. Every pass over the KEY_BYTES key
// bytes clears the 256-bin histogram, counts the digits of all items, forms
// running sums and scatters from last to first; a set of fewer than two items
// skips sorting. Results leave one at a time in ascending key order; after
// every 64 results the block waits for one more input item, which it
// accepts and discards, before the next 64 go out. The set memory holds two
// banks of MAX_ITEMS entries that swap roles each pass; items past MAX_ITEMS
// are dropped and overflowed is raised on all results of that set. Apart from
// that one discarded item, the item channel is stalled throughout sorting and
// output.
module lsd_radix_sort_bytes_top import lsdr_pkg::*; #(
	parameter int MAX_ITEMS    = MAX_ITEMS_DEF,
	parameter int KEY_BYTES    = KEY_BYTES_DEF,
	parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic [KEY_PORT_BITS-1:0]     sort_key,
	input  logic [PAYLOAD_PORT_BITS-1:0] payload,
	input  logic                         final_item,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [KEY_PORT_BITS-1:0]     sorted_key,
	output logic [PAYLOAD_PORT_BITS-1:0] sorted_payload,
	output logic                         last_out,
	output logic                         overflowed
);

	`include "lsd_radix_sort_bytes_top_macros.svh"

	localparam int CW  = $clog2(MAX_ITEMS + 1);
	localparam int AW  = $clog2(MAX_ITEMS);
	localparam int PW  = (PAYLOAD_BITS < PAYLOAD_PORT_BITS) ? PAYLOAD_BITS : PAYLOAD_PORT_BITS;
	localparam int DW  = KEY_PORT_BITS + PW;
	localparam int CHW = $clog2(OUT_CHUNK);
	localparam logic [2:0]       LAST_PASS  = 3'(KEY_BYTES - 1);
	localparam logic [CW-1:0]    MAX_CNT    = CW'(MAX_ITEMS);
	localparam logic [CHW-1:0]   CHUNK_LAST = CHW'(OUT_CHUNK - 1);

	lsdr_state_t state_q;
	logic [CW-1:0]         cnt_q;
	logic                  drop_q;
	logic                  bank_q;
	logic [2:0]            pass_q;
	logic [AW-1:0]         idx_q;
	logic [DIGIT_BITS-1:0] bin_q;
	logic [CW-1:0]         acc_q;
	logic [CW-1:0]         pos_q;
	logic [CHW-1:0]        chunk_q;

	logic                         rvalid_q;
	logic [KEY_PORT_BITS-1:0]     rkey_q;
	logic [PAYLOAD_PORT_BITS-1:0] rpay_q;
	logic                         rlast_q;
	logic                         rovf_q;

	logic          ram_we;
	logic [AW:0]   ram_wa;
	logic [DW-1:0] ram_wd;
	logic [AW:0]   ram_ra;
	logic [DW-1:0] ram_rd;

	logic [CW-1:0] hist_mem [RADIX_BINS];
	logic [CW-1:0] hist_rd_q;
	logic                  hist_we;
	logic [DIGIT_BITS-1:0] hist_wa;
	logic [CW-1:0]         hist_wd;
	logic [DIGIT_BITS-1:0] hist_ra;

	logic                     item_acc;
	logic                     res_acc;
	logic [KEY_PORT_BITS-1:0] rd_key;
	logic [PW-1:0]            rd_pay;
	logic [DIGIT_BITS-1:0]    digit;
	logic [CW-1:0]            cnt_inc;
	logic [CW-1:0]            cnt_new;
	logic [CW-1:0]            cnt_dec;
	logic [CW-1:0]            pos_inc;
	logic [CW-1:0]            dst;
	logic                     has_room;

	// Handshakes
	assign item_stall = !(state_q inside {ST_IDLE, ST_DRAIN});
	assign item_acc   = item_valid && !item_stall;
	assign res_acc    = rvalid_q && !result_stall;

	// Field split and current digit of the item under work
	assign rd_key   = ram_rd[DW-1 -: KEY_PORT_BITS];
	assign rd_pay   = ram_rd[PW-1:0];
	assign digit    = rd_key[{pass_q, 3'b000} +: DIGIT_BITS] & DIGIT_MASK;
	assign has_room = cnt_q < MAX_CNT;
	assign cnt_inc  = cnt_q + CW'(1);
	assign cnt_new  = has_room ? cnt_inc : cnt_q;
	assign cnt_dec  = cnt_q - CW'(1);
	assign pos_inc  = pos_q + CW'(1);
	assign dst      = hist_rd_q - CW'(1);

	// Item memory ports
	always_comb begin
		ram_ra = {bank_q, idx_q};
		if (state_q inside {ST_OUT_RD, ST_OUT_WT, ST_DRAIN}) begin
			ram_ra = {bank_q, pos_q[AW-1:0]};
		end
		ram_we = 1'b0;
		ram_wa = {bank_q, cnt_q[AW-1:0]};
		ram_wd = {sort_key, payload[PW-1:0]};
		if (state_q == ST_IDLE) begin
			ram_we = item_acc && has_room;
		end else if (state_q == ST_SC_W) begin
			ram_we = 1'b1;
			ram_wa = {~bank_q, dst[AW-1:0]};
			ram_wd = ram_rd;
		end
	end

	lsdr_item_ram #(
		.AW(AW + 1),
		.DW(DW)
	) u_ram (
		.clk(clk),
		.wr_en(ram_we),
		.wr_addr(ram_wa),
		.wr_data(ram_wd),
		.rd_addr(ram_ra),
		.rd_data(ram_rd)
	);

	// Histogram ports
	always_comb begin
		hist_ra = (state_q == ST_PFX_RD || state_q == ST_PFX_W) ? bin_q : digit;
		hist_we = 1'b0;
		hist_wa = digit;
		hist_wd = dst;
		case (state_q)
			ST_CLR: begin
				hist_we = 1'b1;
				hist_wa = bin_q;
				hist_wd = '0;
			end
			ST_CNT_W: begin
				hist_we = 1'b1;
				hist_wd = hist_rd_q + CW'(1);
			end
			ST_PFX_W: begin
				hist_we = 1'b1;
				hist_wa = bin_q;
				hist_wd = acc_q + hist_rd_q;
			end
			ST_SC_W: begin
				hist_we = 1'b1;
			end
			default: begin
				hist_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_wa] <= hist_wd;
		end
		hist_rd_q <= hist_mem[hist_ra];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			drop_q   <= 1'b0;
			bank_q   <= 1'b0;
			pass_q   <= '0;
			idx_q    <= '0;
			bin_q    <= '0;
			acc_q    <= '0;
			pos_q    <= '0;
			chunk_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						cnt_q <= cnt_new;
						if (!has_room) begin
							drop_q <= 1'b1;
						end
						if (final_item) begin
							pos_q   <= '0;
							chunk_q <= '0;
							pass_q  <= '0;
							bin_q   <= '0;
							state_q <= (cnt_new < CW'(2)) ? ST_OUT_RD : ST_CLR;
						end
					end
				end
				ST_CLR: begin
					bin_q <= bin_q + 1'b1;
					if (bin_q == DIGIT_MASK) begin
						idx_q   <= '0;
						state_q <= ST_CNT_RD;
					end
				end
				ST_CNT_RD: state_q <= ST_CNT_H;
				ST_CNT_H:  state_q <= ST_CNT_W;
				ST_CNT_W: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == cnt_dec[AW-1:0]) begin
						bin_q   <= '0;
						acc_q   <= '0;
						state_q <= ST_PFX_RD;
					end else begin
						state_q <= ST_CNT_RD;
					end
				end
				ST_PFX_RD: state_q <= ST_PFX_W;
				ST_PFX_W: begin
					acc_q <= acc_q + hist_rd_q;
					bin_q <= bin_q + 1'b1;
					if (bin_q == DIGIT_MASK) begin
						idx_q   <= cnt_dec[AW-1:0];
						state_q <= ST_SC_RD;
					end else begin
						state_q <= ST_PFX_RD;
					end
				end
				ST_SC_RD: state_q <= ST_SC_H;
				ST_SC_H:  state_q <= ST_SC_W;
				ST_SC_W: begin
					if (idx_q == '0) begin
						// swap banks and move to the next byte
						bank_q <= ~bank_q;
						pass_q <= pass_q + 1'b1;
						bin_q  <= '0;
						state_q <= (pass_q == LAST_PASS) ? ST_OUT_RD : ST_CLR;
					end else begin
						idx_q   <= idx_q - 1'b1;
						state_q <= ST_SC_RD;
					end
				end
				ST_OUT_RD: begin
					rvalid_q <= 1'b1;
					state_q  <= ST_OUT_WT;
				end
				ST_OUT_WT: begin
					if (res_acc) begin
						rvalid_q <= 1'b0;
						pos_q    <= pos_inc;
						chunk_q  <= chunk_q + 1'b1;
						if (pos_inc == cnt_q) begin
							// set done: clear for the next one
							cnt_q   <= '0;
							drop_q  <= 1'b0;
							pos_q   <= '0;
							state_q <= ST_IDLE;
						end else if (chunk_q == CHUNK_LAST) begin
							state_q <= ST_DRAIN;
						end else begin
							state_q <= ST_OUT_RD;
						end
					end
				end
				ST_DRAIN: begin
					if (item_acc) begin
						chunk_q <= '0;
						state_q <= ST_OUT_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Show the result item straight from the memory read data
	assign result_valid   = rvalid_q;
	assign sorted_key     = rd_key;
	assign sorted_payload = PAYLOAD_PORT_BITS'(rd_pay);
	assign last_out       = (pos_inc == cnt_q);
	assign overflowed     = drop_q;

	// Track the shown fields for the stall checks below
	always_ff @(posedge clk) begin
		rkey_q  <= sorted_key;
		rpay_q  <= sorted_payload;
		rlast_q <= last_out;
		rovf_q  <= overflowed;
	end

	`LSDR_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= MAX_CNT, "item count above capacity")
	`LSDR_ASSERT_NOW(a_valid_state, rvalid_q, state_q == ST_OUT_WT, "result outside output wait")
	`LSDR_ASSERT_NEXT(a_set_end, res_acc && last_out, cnt_q == '0 && !drop_q, "set not cleared")
	`LSDR_ASSERT_NOW(a_drain_pos, state_q == ST_DRAIN, pos_q < cnt_q, "drain past end of set")
	`LSDR_ASSERT_NEXT(a_stall_data, rvalid_q && result_stall, rkey_q == sorted_key && rpay_q == sorted_payload, "data moved")
	`LSDR_ASSERT_NEXT(a_stall_flags, rvalid_q && result_stall, rlast_q == last_out && rovf_q == overflowed, "flags moved")

endmodule

FILE: test/tb_lsd_radix_sort_bytes_top.sv
`timescale 1ns / 1ps

module tb_lsd_radix_sort_bytes_top;
	import lsdr_pkg::*;

	localparam int SET_CAP = MAX_ITEMS_DEF;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [KEY_PORT_BITS-1:0]     key;
		logic [PAYLOAD_PORT_BITS-1:0] pl;
		logic                         fin;
	} item_t;

	typedef struct packed {
		logic [KEY_PORT_BITS-1:0]     key;
		logic [PAYLOAD_PORT_BITS-1:0] pl;
		logic                         last;
		logic                         ovf;
	} sorted_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [KEY_PORT_BITS-1:0] sort_key = '0;
	logic [PAYLOAD_PORT_BITS-1:0] payload = '0;
	logic final_item = 1'b0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [KEY_PORT_BITS-1:0] sorted_key;
	logic [PAYLOAD_PORT_BITS-1:0] sorted_payload;
	logic last_out;
	logic overflowed;

	item_t pending_items[$];
	sorted_t expected_sorted[$];

	// Predictor state: the set being collected, then sorted and released
	logic [KEY_PORT_BITS-1:0] held_keys[SET_CAP];
	logic [PAYLOAD_PORT_BITS-1:0] held_payloads[SET_CAP];
	int held_n = 0;
	bit held_dropped = 0;
	bit releasing = 0;
	int release_pos = 0;

	int cycle_count = 0;
	int mismatch_count = 0;
	bit stim_done = 0;

	lsd_radix_sort_bytes_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.sort_key      (sort_key),
		.payload       (payload),
		.final_item    (final_item),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.sorted_key    (sorted_key),
		.sorted_payload(sorted_payload),
		.last_out      (last_out),
		.overflowed    (overflowed)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Idle at random, except in one long stretch with no idling
	function automatic bit idle_roll();
		if (cycle_count > 40000 && cycle_count < 120000)
			return 1'b0;
		return $urandom_range(0, 99) < 37;
	endfunction

	// Stable ascending order of the held set by full key
	task automatic order_held_set();
		logic [KEY_PORT_BITS-1:0] k;
		logic [PAYLOAD_PORT_BITS-1:0] p;
		int j;
		for (int i = 1; i < held_n; i++) begin
			k = held_keys[i];
			p = held_payloads[i];
			j = i;
			while (j > 0 && held_keys[j-1] > k) begin
				held_keys[j] = held_keys[j-1];
				held_payloads[j] = held_payloads[j-1];
				j--;
			end
			held_keys[j] = k;
			held_payloads[j] = p;
		end
	endtask

	// Queue up to one chunk of sorted results; close the set at its end
	task automatic release_sorted_chunk();
		sorted_t r;
		int sent;
		sent = 0;
		while (sent < OUT_CHUNK && release_pos < held_n) begin
			r.key = held_keys[release_pos];
			r.pl = held_payloads[release_pos];
			r.last = (release_pos + 1 == held_n);
			r.ovf = held_dropped;
			expected_sorted.push_back(r);
			release_pos++;
			sent++;
		end
		if (release_pos >= held_n) begin
			releasing = 0;
			release_pos = 0;
			held_n = 0;
			held_dropped = 0;
		end
	endtask

	task automatic predict_sorted(item_t it);
		if (releasing) begin
			release_sorted_chunk();
			return;
		end
		if (held_n < SET_CAP) begin
			held_keys[held_n] = it.key;
			held_payloads[held_n] = it.pl;
			held_n++;
		end else begin
			held_dropped = 1;
		end
		if (it.fin) begin
			order_held_set();
			releasing = 1;
			release_pos = 0;
			release_sorted_chunk();
		end
	endtask

	task automatic add_item(logic [63:0] k, logic [31:0] p, logic fin);
		item_t it;
		it.key = k;
		it.pl = p;
		it.fin = fin;
		pending_items.push_back(it);
	endtask

	function automatic logic [63:0] rand_key(int flavor);
		case (flavor)
			0: return '0;
			1: return '1;
			2: return 64'(1) << $urandom_range(0, 63);
			3: return {2'($urandom_range(0, 3)), 60'd0, 2'($urandom_range(0, 3))};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Queue a set, plus one discarded item per extra chunk of output
	task automatic add_set(int n, int flavor_hi);
		int kept;
		for (int i = 0; i < n; i++)
			add_item(rand_key($urandom_range(0, flavor_hi)), $urandom, i == n - 1);
		kept = (n > SET_CAP) ? SET_CAP : n;
		for (int i = 0; i < (kept - 1) / OUT_CHUNK; i++)
			add_item({$urandom, $urandom}, $urandom, $urandom_range(0, 1));
	endtask

	initial begin
		int random_items;
		int n;
		// Single items, extremes, ties and bit walks
		add_item('1, '1, 1'b1);
		add_item('0, '0, 1'b1);
		add_item('1, 32'h1, 1'b0);
		add_item('0, 32'h2, 1'b1);
		add_item(64'd5, 32'hA, 1'b0);
		add_item(64'd5, 32'hB, 1'b0);
		add_item(64'd3, 32'hC, 1'b0);
		add_item(64'd5, 32'hD, 1'b1);
		for (int i = 0; i < 8; i++)
			add_item(64'h80 << (8 * (7 - i)), 32'h5555_0000 | i, i == 7);
		add_set(70, 4);
		random_items = 0;
		while (random_items < 310) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 140) : $urandom_range(1, 12);
			add_set(n, 6);
			random_items += n;
		end
		stim_done = 1;
	end

	// Drive items from the pending queue; predict on each accepted item
	always @(posedge clk or negedge arst_n) begin
		bit holding;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			holding = item_valid;
			if (item_valid && !item_stall) begin
				predict_sorted(pending_items.pop_front());
				holding = 1'b0;
			end
			if (!holding) begin
				if (pending_items.size() > 0 && !idle_roll()) begin
					item_valid <= 1'b1;
					sort_key <= pending_items[0].key;
					payload <= pending_items[0].pl;
					final_item <= pending_items[0].fin;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Stall results at random and check each accepted result
	always @(posedge clk or negedge arst_n) begin
		sorted_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			result_stall <= idle_roll();
			if (result_valid && !result_stall) begin
				if (expected_sorted.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result key=%h payload=%h", sorted_key, sorted_payload);
				end else begin
					want = expected_sorted.pop_front();
					if (sorted_key !== want.key || sorted_payload !== want.pl ||
						last_out !== want.last || overflowed !== want.ovf) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch exp key=%h pl=%h last=%b ovf=%b got key=%h pl=%h last=%b ovf=%b",
								want.key, want.pl, want.last, want.ovf,
								sorted_key, sorted_payload, last_out, overflowed);
					end
				end
			end
		end
	end

	// Hard limit on run length
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		wait (stim_done);
		while (pending_items.size() > 0 || item_valid || expected_sorted.size() > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatch_count == 0 && expected_sorted.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/lsdr_pkg.sv
sv/lsdr_item_ram.sv
sv/lsd_radix_sort_bytes_top.sv
test/tb_lsd_radix_sort_bytes_top.sv
